>>> src/integer_to_ascii_radix_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer to ASCII converter
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes and divider interface types for the
// integer to ASCII converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

    localparam int DATA_W      = 32;  // input number width
    localparam int RADIX_W     = 6;   // radix register width
    localparam int REM_W       = 5;   // remainder always below 32
    localparam int CHAR_W      = 8;
    localparam int STORE_DEPTH = 32;  // longest text: 32 binary digits
    localparam int ADDR_W      = 5;
    localparam int COUNT_W     = 6;   // holds 0..32

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // Divider request from the controller
    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    // Divider response to the controller
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } t_div_rsp;

    // Digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-REM_W){1'b0}}, d};
        if (d > 5'd9) begin
            digit_char = CHAR_A + d_ext - 8'd10;
        end else begin
            digit_char = CHAR_ZERO + d_ext;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/itoa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// itoa_div
// Iterative restoring divider: 32-bit dividend by a 6-bit radix, four
// quotient bits per cycle, with a done pulse once all quotient bits are in.
// ---------------------------------------------------------------------------
module itoa_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire itoa_pkg::t_div_req i_req,
    output itoa_pkg::t_div_rsp      o_rsp
);

    localparam int STEP_BITS = 4;
    localparam int CYCLES    = itoa_pkg::DATA_W / STEP_BITS;
    localparam int CNT_W     = $clog2(CYCLES);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [itoa_pkg::DATA_W-1:0]  r_q;
    logic [itoa_pkg::RADIX_W-1:0] r_rem;
    logic [itoa_pkg::RADIX_W-1:0] r_div;
    logic [itoa_pkg::DATA_W-1:0]  n_q;
    logic [itoa_pkg::RADIX_W-1:0] n_rem;

    // Four shift/compare/subtract steps on the narrow remainder
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < STEP_BITS; i++) begin
            n_rem = {n_rem[itoa_pkg::RADIX_W-2:0], n_q[itoa_pkg::DATA_W-1]};
            n_q   = {n_q[itoa_pkg::DATA_W-2:0], 1'b0};
            if (n_rem >= r_div) begin
                n_rem  = n_rem - r_div;
                n_q[0] = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem[itoa_pkg::REM_W-1:0];

endmodule

`default_nettype wire

>>> src/integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each digit takes one divider pass (4 quotient bits a cycle); a minus sign, when
//   present, and a setup state follow, then each character is read and sent out.
// One number at a time: a new number is taken only once the last character of
//   the previous one, or its empty result, has been loaded into the output register.
// An invalid radix gives a single empty result from S_EMPTY once the output is free.
// Reset: synchronous, active low; radix returns to 10, the digit memory is not cleared.
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Converts a 32-bit number (signed in radix 10, unsigned otherwise) to ASCII text in
// a radix of 2..32, most significant first, one character per output transfer.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_top_macros.svh"

module integer_to_ascii_radix_top #(
    parameter int MAX_CHARS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: radix
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic signed [31:0] i_s_tdata,  // [31:0] number
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,         // [7:0] character
    output logic [0:0]       o_m_tuser,         // [0] is_empty
    output logic             o_m_tlast          // last_char
);

    localparam int EMIT_LIMIT = (MAX_CHARS < itoa_pkg::STORE_DEPTH) ?
                                MAX_CHARS : itoa_pkg::STORE_DEPTH;

    typedef enum logic [2:0] {
        S_IDLE, S_EMPTY, S_DIV, S_SIGN, S_PREP, S_READ, S_LOAD
    } t_state;

    t_state                        r_state;
    logic [itoa_pkg::RADIX_W-1:0]  r_radix;
    logic                          r_neg;
    logic [itoa_pkg::COUNT_W-1:0]  r_count;
    logic [itoa_pkg::ADDR_W-1:0]   r_pos;
    logic [itoa_pkg::COUNT_W-1:0]  r_left;
    logic [itoa_pkg::CHAR_W-1:0]   r_rd_data;
    logic                          r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]   r_out_char;
    logic                          r_out_empty;
    logic                          r_out_last;

    logic [itoa_pkg::CHAR_W-1:0]   r_store [itoa_pkg::STORE_DEPTH];

    logic                          w_in_xfer;
    logic                          w_radix_ok;
    logic                          w_neg;
    logic [itoa_pkg::DATA_W-1:0]   w_mag;
    logic                          w_out_free;
    logic                          w_we;
    logic [itoa_pkg::CHAR_W-1:0]   w_wdata;
    itoa_pkg::t_div_req            w_div_req;
    itoa_pkg::t_div_rsp            w_div_rsp;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itoa_pkg::RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_data;
        end
    end

    // Input decode
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_radix_ok = (r_radix >= itoa_pkg::RADIX_MIN) && (r_radix <= itoa_pkg::RADIX_MAX);
    assign w_neg      = (r_radix == itoa_pkg::RADIX_DEC) && i_s_tdata[31];
    assign w_mag      = w_neg ? (32'd0 - $unsigned(i_s_tdata)) : $unsigned(i_s_tdata);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Divider: restarts on the previous quotient until it reaches zero
    assign w_div_req.start    = (w_in_xfer && w_radix_ok) ||
                                (r_state == S_DIV && w_div_rsp.done &&
                                 w_div_rsp.quot != '0);
    assign w_div_req.dividend = (r_state == S_IDLE) ? w_mag : w_div_rsp.quot;
    assign w_div_req.divisor  = r_radix;

    itoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Digit memory, least significant character at address 0
    assign w_we    = (r_state == S_DIV && w_div_rsp.done) || (r_state == S_SIGN);
    assign w_wdata = (r_state == S_SIGN) ? itoa_pkg::CHAR_MINUS :
                     itoa_pkg::digit_char(w_div_rsp.rem);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_count[itoa_pkg::ADDR_W-1:0]] <= w_wdata;
        end
        r_rd_data <= r_store[r_pos];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_pos       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_out_char  <= '0;
            r_out_empty <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_count <= '0;
                        r_neg   <= w_neg;
                        r_state <= w_radix_ok ? S_DIV : S_EMPTY;
                    end
                end
                S_EMPTY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= itoa_pkg::CHAR_NONE;
                        r_out_empty <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_count <= r_count + 1'b1;
                        if (w_div_rsp.quot == '0) begin
                            r_state <= r_neg ? S_SIGN : S_PREP;
                        end
                    end
                end
                S_SIGN: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    // start from the most significant character
                    r_pos   <= r_count[itoa_pkg::ADDR_W-1:0] - 1'b1;
                    r_left  <= (r_count < itoa_pkg::COUNT_W'(EMIT_LIMIT)) ?
                               r_count : itoa_pkg::COUNT_W'(EMIT_LIMIT);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= r_rd_data;
                        r_out_empty <= 1'b0;
                        r_out_last  <= (r_left == itoa_pkg::COUNT_W'(1));
                        if (r_left == itoa_pkg::COUNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos - 1'b1;
                            r_left  <= r_left - 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tuser  = r_out_empty;
    assign o_m_tlast  = r_out_last;

    // Checks
    `ITOA_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV, "divider finished outside the division state")
    `ITOA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= itoa_pkg::COUNT_W'(itoa_pkg::STORE_DEPTH), "digit count exceeds store depth")
    `ITOA_ASSERT_SAME(a_load_left, i_clk, i_rst_n, r_state == S_LOAD, r_left != '0, "character load with nothing left to send")
    `ITOA_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tlast && o_m_tdata == itoa_pkg::CHAR_NONE, "empty result not a lone last transfer")
    `ITOA_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer, !o_s_tready, "input taken while a number is in progress")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the integer to ASCII converter. Numbers are streamed in under
// several radix settings, both valid and invalid. The expected characters are
// worked out by repeated division in the bench and compared one transfer at
// a time against the output stream. The sender idles in bursts and the
// receiver stalls on its own pattern, including one long hold-off.
// ---------------------------------------------------------------------------
module testbench;

    localparam int MAX_TEXT = 32;  // block default for MAX_CHARS

    typedef struct {
        logic [itoa_pkg::CHAR_W-1:0] ch;
        logic                        is_empty;
        logic                        last;
    } t_ascii_char;

    typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} t_sink_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [5:0]  i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = '0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    // Bench copy of the radix register and the characters still to come
    logic [itoa_pkg::RADIX_W-1:0] radix_shadow = itoa_pkg::RADIX_RESET;
    t_ascii_char                  expected_chars[$];
    t_ascii_char                  head;
    int                           mismatch_count = 0;

    // Sender and receiver pacing
    bit          sender_gaps  = 1'b0;
    int          burst_left   = 0;
    t_sink_mode  sink_mode    = SINK_ALWAYS;
    int          sink_duty    = 100;
    logic [15:0] sink_pattern = 16'hFFFF;
    int          sink_tick    = 0;
    int          hold_request = 0;
    int          hold_left    = 0;

    integer_to_ascii_radix_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Text of one number in the current radix, most significant first
    function automatic void predict_text(input logic [31:0] number);
        logic [31:0]                 mag;
        logic [4:0]                  rem;
        logic [itoa_pkg::CHAR_W-1:0] digits[$];
        t_ascii_char                 c;
        bit                          negative;
        int                          emit;
        if (radix_shadow < itoa_pkg::RADIX_MIN || radix_shadow > itoa_pkg::RADIX_MAX) begin
            c.ch       = itoa_pkg::CHAR_NONE;
            c.is_empty = 1'b1;
            c.last     = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        // sign only in base 10; elsewhere the raw 32-bit pattern
        negative = (radix_shadow == itoa_pkg::RADIX_DEC) && number[31];
        mag = negative ? (32'd0 - number) : number;
        do begin
            rem = 5'(mag % radix_shadow);
            if (rem > 5'd9) begin
                digits.push_front(itoa_pkg::CHAR_A + 8'(rem) - 8'd10);
            end else begin
                digits.push_front(itoa_pkg::CHAR_ZERO + 8'(rem));
            end
            mag = mag / radix_shadow;
        end while (mag != 0);
        if (negative) begin
            digits.push_front(itoa_pkg::CHAR_MINUS);
        end
        emit = (digits.size() < MAX_TEXT) ? digits.size() : MAX_TEXT;
        for (int k = 0; k < emit; k++) begin
            c.ch       = digits[k];
            c.is_empty = 1'b0;
            c.last     = (k == emit - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // One number into the input stream; bursts separated by random gaps
    task automatic send_number(input logic [31:0] number);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= number;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_text(number);
    endtask

    // Stop sending and let every pending character come out
    task automatic finish_pending();
        i_s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Radix write, only once the block is idle
    task automatic set_radix(input logic [5:0] value);
        finish_pending();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        radix_shadow = value;
    endtask

    function automatic logic [31:0] pick_number();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 40);
            2: return 32'd0 - $urandom_range(1, 40);
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic pick_sink_mode();
        case ($urandom_range(0, 2))
            0: sink_mode = SINK_ALWAYS;
            1: begin
                sink_mode = SINK_RANDOM;
                sink_duty = $urandom_range(25, 95);
            end
            default: begin
                sink_mode    = SINK_PATTERN;
                sink_pattern = 16'($urandom()) | 16'h0001;
            end
        endcase
    endtask

    // Base 10 from reset: sign, zero and both ends of the range
    task automatic test_decimal_text();
        sender_gaps = 1'b0;
        sink_mode   = SINK_ALWAYS;
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd1234567890);
    endtask

    // Smallest and largest valid radix, then base 16, negatives shown unsigned
    task automatic test_radix_bounds();
        sender_gaps = 1'b1;
        sink_mode   = SINK_RANDOM;
        sink_duty   = 60;
        set_radix(itoa_pkg::RADIX_MIN);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd5);
        set_radix(itoa_pkg::RADIX_MAX);
        send_number(32'd31);
        send_number(32'd32);
        send_number(32'hFFFF_FFFF);
        set_radix(6'd16);
        send_number(32'hDEAD_BEEF);
        send_number(32'h7FFF_FFFF);
    endtask

    // Out-of-range radix gives one empty result per number
    task automatic test_invalid_radix();
        sink_mode = SINK_PATTERN;
        sink_pattern = 16'b1011_0010_1110_0101;
        set_radix(6'd0);
        send_number(32'h1234_5678);
        set_radix(6'd1);
        send_number(32'hFFFF_FFFF);
        set_radix(6'd33);
        send_number(32'd0);
        set_radix(6'd63);
        send_number(32'h8000_0000);
    endtask

    // Random numbers over random radix settings and pacing
    task automatic test_random_text();
        int choice;
        for (int phase = 0; phase < 8; phase++) begin
            choice = $urandom_range(0, 9);
            if (choice == 0) begin
                set_radix(($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 1))
                                                      : 6'($urandom_range(33, 63)));
            end else if (choice <= 2) begin
                set_radix(itoa_pkg::RADIX_DEC);
            end else begin
                set_radix(6'($urandom_range(2, 32)));
            end
            sender_gaps = ($urandom_range(0, 2) != 0);
            pick_sink_mode();
            for (int n = 0; n < 16; n++) begin
                send_number(pick_number());
            end
        end
    endtask

    // Long receiver hold-off while numbers keep coming, so the input stalls
    task automatic test_output_backpressure();
        set_radix(6'd16);
        sender_gaps  = 1'b0;
        sink_mode    = SINK_ALWAYS;
        hold_request = 300;
        for (int n = 0; n < 12; n++) begin
            send_number($urandom());
        end
    endtask

    // Receiver ready: long hold-off first, otherwise the chosen pattern
    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS: i_m_tready <= 1'b1;
                SINK_RANDOM: i_m_tready <= ($urandom_range(0, 99) < sink_duty);
                default:     i_m_tready <= sink_pattern[sink_tick % 16];
            endcase
        end
    end

    // Compare each output transfer with the oldest expected character
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer: expected none, actual char %h empty %b last %b",
                         $time, o_m_tdata, o_m_tuser[0], o_m_tlast);
            end else begin
                head = expected_chars.pop_front();
                if (o_m_tdata !== head.ch || o_m_tuser[0] !== head.is_empty
                        || o_m_tlast !== head.last) begin
                    mismatch_count++;
                    $display("%0t: expected char %h empty %b last %b, %s %h empty %b last %b",
                             $time, head.ch, head.is_empty, head.last, "actual char",
                             o_m_tdata, o_m_tuser[0], o_m_tlast);
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decimal_text();
        test_radix_bounds();
        test_invalid_radix();
        test_random_text();
        test_output_backpressure();
        finish_pending();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
